// File: design/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// Holds the transfer payload structs, command codes and table request types.
// No dependencies.
package hcbp_pkg;

    // Command codes carried in the input item.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Fixed field and buffer widths.
    localparam int CODE_W    = 24;
    localparam int LEN_W     = 5;
    localparam int SYM_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    localparam int ACC_W     = PEND_W + CODE_W;
    localparam int CNT_W     = 5;
    localparam int TBL_DEPTH = 256;
    localparam int ENTRY_W   = CODE_W + LEN_W;

    // Input item payload.
    typedef struct packed {
        logic [1:0]        command;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    // Result item payload.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_item;

    // Request from the packer control to the code table.
    typedef struct packed {
        logic              wr_en;
        logic [SYM_W-1:0]  addr;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_tbl_req;

    // One code table entry as read back.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_entry;

    // Packer control states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    // Mask with the low n bits set, for the pending bit buffer.
    function automatic logic [PEND_W-1:0] low_mask(input logic [PCNT_W-1:0] n);
        logic [PEND_W-1:0] m;
        for (int i = 0; i < PEND_W; i++) begin
            m[i] = (PCNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// File: design/hcbp_ram.sv
// Generic single-port RAM with a registered read port.
// One write or read address per cycle; read data is registered and appears in the next cycle.
// No dependencies.
module hcbp_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/hcbp_table.sv
// Code table: a 256-entry RAM of code words and lengths with per-entry valid bits.
// Entries not yet loaded since reset read as zero code and zero length.
// Depends on hcbp_pkg and hcbp_ram.
module hcbp_table #(
    parameter int MAX_CODE_LEN = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hcbp_pkg::t_tbl_req    i_req,
    output hcbp_pkg::t_tbl_entry  o_entry
);
    import hcbp_pkg::*;

    // Effective length limit: the parameter, and never more than the code word.
    localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

    logic [TBL_DEPTH-1:0] r_valid;
    logic                 r_rd_valid;
    logic [LEN_W-1:0]     wr_len;
    logic [CODE_W-1:0]    wr_code;
    t_tbl_entry           wr_entry;
    logic [ENTRY_W-1:0]   rd_data;

    // Clamp the length and clear code bits above it before storing.
    always_comb begin
        wr_len = (i_req.len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_req.len;
        for (int i = 0; i < CODE_W; i++) begin
            wr_code[i] = i_req.code[i] & (LEN_W'(i) < wr_len);
        end
        wr_entry.len  = wr_len;
        wr_entry.code = wr_code;
    end

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_addr  (i_req.addr),
        .i_wdata (wr_entry),
        .o_rdata (rd_data)
    );

    // Valid bits mark entries written since reset; the lookup follows the RAM read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_req.addr];
        end
    end

    assign o_entry = r_rd_valid ? t_tbl_entry'(rd_data) : '0;

endmodule

// File: design/huffman_code_bit_packer.sv
// Huffman code bit packer: input item channel and packed byte result channel.
// Every item transfer carries a command. Load writes a code word and length
// into the 256-entry code table. Encode reads the symbol's entry from the
// table RAM, appends its code MSB first to the pending bits and then sends
// each completed byte, one per cycle while the receiver does not stall, up to
// three; the last byte of the item has last set. Flush pads the pending
// bits with zeros on the right and sends them as one byte with last set, or
// does nothing when no bits are pending. Command 3 is ignored.
// An encode item passes through the lookup state and, when a byte is
// complete, the emit state; a flush with bits pending goes to the emit state,
// and the block stays idle for other items.
// The result sits in an output register, so a new item is taken while the
// last byte still waits. When the receiver stalls, byte emission pauses and
// o_in_stall stays high until the item is done. Reset clears the code table
// (all entries read as length zero) and the pending bits at once.
// Depends on hcbp_pkg and hcbp_table.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hcbp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hcbp_pkg::t_out_item o_out_data
);
    import hcbp_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [PEND_W-1:0]  r_pend;
    logic [PCNT_W-1:0]  r_pcnt;
    logic [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    t_out_item          r_out_data;

    t_tbl_req           tbl_req;
    t_tbl_entry         tbl_entry;
    logic               in_fire;
    logic               emit_fire;
    logic [ACC_W-1:0]   acc_new;
    logic [CNT_W-1:0]   cnt_new;
    logic [CNT_W-1:0]   shift_amt;
    logic [BYTE_W-1:0]  emit_byte;
    logic               emit_last;
    logic [BYTE_W-1:0]  flush_byte;

    hcbp_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_entry (tbl_entry)
    );

    // Handshake qualifiers.
    assign in_fire   = i_in_valid && !o_in_stall;
    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // Append the looked-up code to the pending bits.
    assign acc_new = (ACC_W'(r_pend) << tbl_entry.len) | ACC_W'(tbl_entry.code);
    assign cnt_new = CNT_W'(r_pcnt) + tbl_entry.len;

    // Next byte to send is the top eight of the remaining bits.
    assign shift_amt = r_cnt - CNT_W'(BYTE_W);
    assign emit_byte = BYTE_W'(r_acc >> shift_amt);
    assign emit_last = (shift_amt < CNT_W'(BYTE_W));

    // Flush byte: pending bits moved to the top, zeros on the right.
    assign flush_byte = BYTE_W'(15'(r_pend) << (4'(BYTE_W) - 4'(r_pcnt)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.command == CMD_ENCODE) begin
                        n_state = ST_LOOKUP;
                    end else if (i_in_data.command == CMD_FLUSH && r_pcnt != '0) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_LOOKUP: begin
                n_state = (cnt_new >= CNT_W'(BYTE_W)) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (emit_fire && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs: input stall and table request.
    always_comb begin
        o_in_stall    = 1'b1;
        tbl_req.wr_en = 1'b0;
        tbl_req.addr  = i_in_data.symbol;
        tbl_req.code  = i_in_data.code_word;
        tbl_req.len   = i_in_data.code_length;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                tbl_req.wr_en = i_in_valid && (i_in_data.command == CMD_LOAD);
            end
            ST_LOOKUP: begin
                o_in_stall = 1'b1;
            end
            ST_EMIT: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Control state, pending bit buffer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOOKUP && cnt_new < CNT_W'(BYTE_W)) begin
                r_pend <= acc_new[PEND_W-1:0] & low_mask(cnt_new[PCNT_W-1:0]);
                r_pcnt <= cnt_new[PCNT_W-1:0];
            end else if (emit_fire && emit_last) begin
                r_pend <= r_acc[PEND_W-1:0] & low_mask(shift_amt[PCNT_W-1:0]);
                r_pcnt <= shift_amt[PCNT_W-1:0];
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working bit accumulator and output payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_fire && i_in_data.command == CMD_FLUSH) begin
            r_acc <= ACC_W'(flush_byte);
            r_cnt <= CNT_W'(BYTE_W);
        end else if (r_state == ST_LOOKUP) begin
            r_acc <= acc_new;
            r_cnt <= cnt_new;
        end else if (emit_fire) begin
            r_cnt <= shift_amt;
        end
        if (emit_fire) begin
            r_out_data.out_byte <= emit_byte;
            r_out_data.last     <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sim/huffman_code_bit_packer_checker.sv
// Checker for the Huffman code bit packer: watches both channels, predicts the packed bytes.
// Keeps its own code table and pending bit buffer, and compares every result transfer.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module huffman_code_bit_packer_checker #(
    parameter int MAX_CODE_LEN = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  hcbp_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  hcbp_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_outstanding,
    output int                  o_bytes_checked
);
    import hcbp_pkg::*;

    // Code lengths are limited by the parameter and by the width of the code word.
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [CODE_W-1:0] code_tbl [TBL_DEPTH];
    logic [LEN_W-1:0]  len_tbl  [TBL_DEPTH];
    logic [PEND_W-1:0] pend_bits;
    logic [PCNT_W-1:0] pend_cnt;
    t_out_item         expected_bytes [$];
    int                fail_count    = 0;
    int                bytes_checked = 0;
    int                outstanding   = 0;

    assign o_fail_count    = fail_count;
    assign o_outstanding   = outstanding;
    assign o_bytes_checked = bytes_checked;

    // Update the table or the bit buffer for one input transfer and queue the bytes it yields.
    task automatic pack_bytes(input t_in_item item);
        logic [63:0] acc;
        int unsigned len;
        int unsigned cnt;
        int unsigned n_out;
        t_out_item   res;
        case (item.command)
            CMD_LOAD: begin
                len = item.code_length;
                if (len > LEN_CAP) begin
                    len = LEN_CAP;
                end
                code_tbl[item.symbol] = item.code_word & CODE_W'((64'd1 << len) - 64'd1);
                len_tbl[item.symbol]  = LEN_W'(len);
            end
            CMD_ENCODE: begin
                len   = len_tbl[item.symbol];
                acc   = (64'(pend_bits) << len) | 64'(code_tbl[item.symbol]);
                cnt   = pend_cnt + len;
                n_out = 0;
                // Bytes leave oldest first; the last one of the item is marked.
                while (cnt >= 8 && n_out < 3) begin
                    cnt          = cnt - 8;
                    n_out        = n_out + 1;
                    res.out_byte = 8'(acc >> cnt);
                    res.last     = (cnt < 8) || (n_out == 3);
                    expected_bytes.push_back(res);
                end
                pend_bits = PEND_W'(acc & ((64'd1 << cnt) - 64'd1));
                pend_cnt  = PCNT_W'(cnt);
            end
            CMD_FLUSH: begin
                // Leftover bits are padded with zeros on the right.
                if (pend_cnt != 0) begin
                    res.out_byte = 8'(16'(pend_bits) << (8 - pend_cnt));
                    res.last     = 1'b1;
                    expected_bytes.push_back(res);
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Compare result transfers with the oldest expectation, then predict from input transfers.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                code_tbl[i] = '0;
                len_tbl[i]  = '0;
            end
            pend_bits = '0;
            pend_cnt  = '0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %02h last %0b",
                           i_out_data.out_byte, i_out_data.last);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (i_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, i_out_data.out_byte);
                        fail_count++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, i_out_data.last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pack_bytes(i_in_data);
            end
        end
        outstanding = expected_bytes.size();
    end

endmodule

// File: sim/huffman_code_bit_packer_tb.sv
// Testbench top for the Huffman code bit packer: clock, reset, stimulus and verdict.
// Drives load, encode, flush and unused commands with random idling on both channels.
// Depends on hcbp_pkg, huffman_code_bit_packer and huffman_code_bit_packer_checker.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
    import hcbp_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         MAX_CODE_LEN   = 24;
    localparam int         RANDOM_ITEMS   = 250;
    localparam int         RX_HOLD_CYCLES = 120;
    localparam int         SETTLE_CYCLES  = 20;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    int fail_count;
    int outstanding;
    int bytes_checked;

    bit         tx_idle     = 1'b1;
    bit         rx_idle     = 1'b1;
    int         hold_cycles = 0;
    logic [7:0] loaded_syms [$];
    int         n_load      = 0;
    int         n_encode    = 0;
    int         n_flush     = 0;
    int         n_unused    = 0;

    always #5 clk = ~clk;

    huffman_code_bit_packer #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    huffman_code_bit_packer_checker #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) pack_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_bytes_checked(bytes_checked)
    );

    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [7:0] sym,
                                           input logic [23:0] code, input logic [4:0] len);
        t_in_item item;
        item.command     = cmd;
        item.symbol      = sym;
        item.code_word   = code;
        item.code_length = len;
        return item;
    endfunction

    // Mostly encodes of loaded symbols with loads, flushes and some noise mixed in, or only loads.
    function automatic t_in_item random_item(input bit load_only);
        t_in_item    item;
        int unsigned pick;
        int unsigned len_pick;
        item = make_item(CMD_ENCODE, 8'($urandom), 24'($urandom), 5'($urandom));
        pick = $urandom_range(0, 99);
        if (load_only || pick < 15) begin
            item.command = CMD_LOAD;
            len_pick     = $urandom_range(0, 99);
            if (len_pick < 80) begin
                item.code_length = 5'($urandom_range(1, 24));
            end else if (len_pick < 90) begin
                item.code_length = '0;
            end else begin
                item.code_length = 5'($urandom_range(25, 31));
            end
        end else if (pick < 88) begin
            if (loaded_syms.size() != 0 && $urandom_range(0, 99) < 85) begin
                item.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
        end else if (pick < 97) begin
            item.command = CMD_FLUSH;
        end else begin
            item.command = CMD_UNUSED;
        end
        return item;
    endfunction

    // Offer one item, with a random idle gap first when idling is on, and return at the edge of its transfer.
    task automatic send_item(input t_in_item item);
        if (tx_idle && $urandom_range(0, 99) < 38) begin
            in_valid <= 1'b0;
            in_data  <= t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
            do begin
                @(posedge clk);
            end while ($urandom_range(0, 99) < 38);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        case (item.command)
            CMD_LOAD: begin
                n_load++;
                loaded_syms.push_back(item.symbol);
            end
            CMD_ENCODE: n_encode++;
            CMD_FLUSH:  n_flush++;
            default:    n_unused++;
        endcase
    endtask

    // Stop offering and wait until every predicted byte has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    // Receiver: random stall, or a long hold-off counted down here.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                out_stall <= rx_idle && ($urandom_range(0, 99) < 38);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, flush with nothing pending and the unused command.
        send_item(make_item(CMD_ENCODE, 8'h00, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_FLUSH, 8'($urandom), 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_UNUSED, 8'h5A, 24'h000000, 5'd0));
        // Loads: full length, clamped length, bits above the length, zero length.
        send_item(make_item(CMD_LOAD, 8'hFF, 24'hFFFFFF, 5'd24));
        send_item(make_item(CMD_LOAD, 8'h00, 24'hFFFFFF, 5'd31));
        send_item(make_item(CMD_LOAD, 8'h01, 24'hABCDE5, 5'd3));
        send_item(make_item(CMD_LOAD, 8'h02, 24'h123456, 5'd0));
        send_item(make_item(CMD_LOAD, 8'h80, 24'h7FFFFE, 5'd1));
        send_item(make_item(CMD_LOAD, 8'h7F, 24'h000001, 5'd25));
        // A few bits pending, a zero-length symbol, then a flush.
        send_item(make_item(CMD_ENCODE, 8'h01, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_ENCODE, 8'h02, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_FLUSH, 8'h00, 24'h000000, 5'd0));
        // Seven bits pending plus a 24-bit code gives three bytes and seven left over.
        send_item(make_item(CMD_ENCODE, 8'h01, 24'h000000, 5'd0));
        send_item(make_item(CMD_ENCODE, 8'h01, 24'hFFFFFF, 5'd31));
        send_item(make_item(CMD_ENCODE, 8'h80, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_ENCODE, 8'hFF, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_FLUSH, 8'hFF, 24'hFFFFFF, 5'd31));
        // Byte-aligned 24-bit codes, a flush that finds nothing, then a short code, a flush and an unused command.
        send_item(make_item(CMD_ENCODE, 8'h00, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_FLUSH, 8'($urandom), 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_ENCODE, 8'h7F, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_ENCODE, 8'h01, 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_FLUSH, 8'($urandom), 24'($urandom), 5'($urandom)));
        send_item(make_item(CMD_UNUSED, 8'hFF, 24'hFFFFFF, 5'h1F));

        // Random part: a table setup, then mostly encodes.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 90) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_cycles = RX_HOLD_CYCLES;
                tx_idle     = 1'b0;
            end else if (i == 115) begin
                tx_idle = 1'b1;
            end else if (i == 150) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else if (i == 200) begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end else if (i == 220) begin
                wait_drained();
            end
            send_item(random_item(i < 24));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d loads, %0d encodes, %0d flushes and %0d unused commands.",
                 n_load, n_encode, n_flush, n_unused);
        $display("%0d packed bytes compared, %0d still outstanding.", bytes_checked,
                 outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/hcbp_table.sv
design/huffman_code_bit_packer.sv
sim/huffman_code_bit_packer_checker.sv
sim/huffman_code_bit_packer_tb.sv
